@@ rtl/tam_pkg.sv @@
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types, constants and the colour table of the tilt activity meter.
// ----------------------------------------------------------------------------
`default_nettype none

package tam_pkg;

  localparam int HISTORY_DEPTH = 10;

  localparam int CNT_W      = 16;
  localparam int LVL_W      = 2;
  localparam int GRADE_W    = 3;
  localparam int DUTY_W     = 7;
  localparam int TALLY_W    = 4;
  localparam int LIMIT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_LVL    = 4;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [LVL_W-1:0] {
    LVL_NONE   = 2'd0,
    LVL_LOW    = 2'd1,
    LVL_MEDIUM = 2'd2,
    LVL_HIGH   = 2'd3
  } level_t;

  typedef enum logic [GRADE_W-1:0] {
    GRADE_F = 3'd0,
    GRADE_E = 3'd1,
    GRADE_D = 3'd2,
    GRADE_C = 3'd3,
    GRADE_B = 3'd4,
    GRADE_A = 3'd5
  } grade_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEW_LIMIT          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MANY_LIMIT         = 3'd5;

  localparam logic [CNT_W-1:0]   RST_SAMPLES_PER_WINDOW = 16'd1000;
  localparam logic [CNT_W-1:0]   RST_LOW_THRESHOLD      = 16'd10;
  localparam logic [CNT_W-1:0]   RST_MEDIUM_THRESHOLD   = 16'd100;
  localparam logic [CNT_W-1:0]   RST_HIGH_THRESHOLD     = 16'd200;
  localparam logic [LIMIT_W-1:0] RST_FEW_LIMIT          = 4'd3;
  localparam logic [LIMIT_W-1:0] RST_MANY_LIMIT         = 4'd6;

  typedef struct packed {
    logic             last;   // this item closes the window
    logic [CNT_W-1:0] count;  // changes including this item
  } win_stat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } duty_rgb_t;

  function automatic duty_rgb_t grade_colour(input grade_t g);
    duty_rgb_t c;
    unique case (g)
      GRADE_F: c = '{red: 7'd100, green: 7'd0,   blue: 7'd0};
      GRADE_E: c = '{red: 7'd100, green: 7'd10,  blue: 7'd0};
      GRADE_D: c = '{red: 7'd100, green: 7'd30,  blue: 7'd0};
      GRADE_C: c = '{red: 7'd0,   green: 7'd100, blue: 7'd0};
      GRADE_B: c = '{red: 7'd0,   green: 7'd100, blue: 7'd80};
      GRADE_A: c = '{red: 7'd0,   green: 7'd0,   blue: 7'd100};
      default: c = '{red: 7'd100, green: 7'd0,   blue: 7'd0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tilt_activity_intensity_meter.sv @@
// ----------------------------------------------------------------------------
// tilt_activity_intensity_meter
// Counts tilt changes per window, grades them and rates recent activity.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one tilt sample per item, in_tdata[0].
//   out_*  : one result item at the end of every window of samples_per_window
//            items (0 acts as 1); no result for the other items.
//   cfg_*  : register writes, always ready, index 0..5, others ignored.
// Timing: the result of the item that closes a window is on out_* in the cycle
//   after that item is accepted. Throughput is one item per cycle while no
//   closing item waits on a stalled receiver; the window counter updates as an
//   item is taken, the history chain and the tally as a closing item is taken.
// The level history is a chain of HISTORY_DEPTH cells shifting at each window
//   end; the last cell gives the level that leaves the tally.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
//   counters, fills the history with none and empties the output register.
// When the receiver stalls, items that do not close a window are still taken;
//   only an item that would close a window waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_activity_intensity_meter
  import tam_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input items
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [0] tilt_sample, [7:1] zero
  // result items
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [15:0] activation_count, [17:16] activity_level, [20:18] intensity_grade,
  // [27:21] red_duty, [34:28] green_duty, [41:35] blue_duty, [47:42] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [CNT_W-1:0]   samples_r;
  logic [CNT_W-1:0]   low_thr_r;
  logic [CNT_W-1:0]   med_thr_r;
  logic [CNT_W-1:0]   high_thr_r;
  logic [LIMIT_W-1:0] few_r;
  logic [LIMIT_W-1:0] many_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r  <= RST_SAMPLES_PER_WINDOW;
      low_thr_r  <= RST_LOW_THRESHOLD;
      med_thr_r  <= RST_MEDIUM_THRESHOLD;
      high_thr_r <= RST_HIGH_THRESHOLD;
      few_r      <= RST_FEW_LIMIT;
      many_r     <= RST_MANY_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_WINDOW: samples_r  <= cfg_data;
        REG_LOW_THRESHOLD:      low_thr_r  <= cfg_data;
        REG_MEDIUM_THRESHOLD:   med_thr_r  <= cfg_data;
        REG_HIGH_THRESHOLD:     high_thr_r <= cfg_data;
        REG_FEW_LIMIT:          few_r      <= cfg_data[LIMIT_W-1:0];
        REG_MANY_LIMIT:         many_r     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic      in_accept;
  logic      window_end;
  win_stat_t stat;
  logic      out_valid_r;

  assign in_tready  = !stat.last || !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign window_end = in_accept && stat.last;

  tam_window u_window (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (in_accept),
    .tilt               (in_tdata[0]),
    .samples_per_window (samples_r),
    .stat               (stat)
  );

  // grading, high threshold first
  level_t lvl_new;

  always_comb begin
    if (stat.count >= high_thr_r) begin
      lvl_new = LVL_HIGH;
    end else if (stat.count >= med_thr_r) begin
      lvl_new = LVL_MEDIUM;
    end else if (stat.count >= low_thr_r) begin
      lvl_new = LVL_LOW;
    end else begin
      lvl_new = LVL_NONE;
    end
  end

  // history chain
  level_t hist [HISTORY_DEPTH+1];
  level_t lvl_old;

  assign hist[0] = lvl_new;
  assign lvl_old = hist[HISTORY_DEPTH];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
    tam_hist_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (window_end),
      .level_in  (hist[i]),
      .level_out (hist[i+1])
    );
  end

  // level tally, updated incrementally
  logic [TALLY_W-1:0] tally_r   [NUM_LVL];
  logic [TALLY_W-1:0] tally_nxt [NUM_LVL];

  always_comb begin
    for (int k = 0; k < NUM_LVL; k++) begin
      tally_nxt[k] = tally_r[k];
      if ((lvl_old == level_t'(k)) && (tally_r[k] != '0)) begin
        tally_nxt[k] = tally_nxt[k] - TALLY_W'(1);
      end
      if (lvl_new == level_t'(k)) begin
        tally_nxt[k] = tally_nxt[k] + TALLY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LVL; k++) begin
        tally_r[k] <= (k == int'(LVL_NONE)) ? TALLY_W'(HISTORY_DEPTH) : '0;
      end
    end else if (window_end) begin
      for (int k = 0; k < NUM_LVL; k++) begin
        tally_r[k] <= tally_nxt[k];
      end
    end
  end

  // intensity from the updated tally, later rules win
  grade_t    grade;
  duty_rgb_t colour;

  always_comb begin
    grade = GRADE_F;
    if (tally_nxt[LVL_LOW]    >= few_r)  grade = GRADE_E;
    if (tally_nxt[LVL_LOW]    >= many_r) grade = GRADE_D;
    if (tally_nxt[LVL_MEDIUM] >= few_r)  grade = GRADE_C;
    if (tally_nxt[LVL_MEDIUM] >= many_r) grade = GRADE_B;
    if (tally_nxt[LVL_HIGH]   >= many_r) grade = GRADE_A;
    colour = grade_colour(grade);
  end

  // output register
  logic [CNT_W-1:0] out_count_r;
  level_t           out_level_r;
  grade_t           out_grade_r;
  duty_rgb_t        out_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (window_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (window_end) begin
      out_count_r  <= stat.count;
      out_level_r  <= lvl_new;
      out_grade_r  <= grade;
      out_colour_r <= colour;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_colour_r.blue, out_colour_r.green, out_colour_r.red,
                       out_grade_r, out_level_r, out_count_r};

  // tally entries always add up to the history depth
  logic [TALLY_W+1:0] tally_sum;
  assign tally_sum = (TALLY_W+2)'(tally_r[0]) + (TALLY_W+2)'(tally_r[1])
                   + (TALLY_W+2)'(tally_r[2]) + (TALLY_W+2)'(tally_r[3]);

  a_tally_sum: assert property (@(posedge clk) disable iff (!rst_n)
    tally_sum == (TALLY_W+2)'(HISTORY_DEPTH))
    else $error("level tally does not sum to history depth");

  a_window_result: assert property (@(posedge clk) disable iff (!rst_n)
    window_end |=> out_valid_r)
    else $error("window end did not load a result");

  a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && stat.last && !out_tready))
    else $error("input stalled without a pending window end");

  a_grade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_grade_r <= GRADE_A))
    else $error("intensity grade out of range");

endmodule

`default_nettype wire

@@ rtl/tam_hist_cell.sv @@
// ----------------------------------------------------------------------------
// tam_hist_cell
// One slot of the level history chain; passes its level on at each window end.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_hist_cell
  import tam_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   shift_en,
  input  wire level_t level_in,
  output level_t      level_out
);

  level_t level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_NONE;
    end else if (shift_en) begin
      level_r <= level_in;
    end
  end

  assign level_out = level_r;

endmodule

`default_nettype wire

@@ rtl/tam_window.sv @@
// ----------------------------------------------------------------------------
// tam_window
// Window tick counter and saturating change counter of the tilt level.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_window
  import tam_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             tilt,
  input  wire logic [CNT_W-1:0] samples_per_window,
  output win_stat_t             stat
);

  logic             prev_tilt_r;
  logic [CNT_W-1:0] tick_r;
  logic [CNT_W-1:0] change_r;

  logic [CNT_W-1:0] win_eff;
  logic             change;
  logic             bump;

  always_comb begin
    win_eff   = (samples_per_window == '0) ? CNT_W'(1) : samples_per_window;
    // first sample of a window only loads the reference level
    change    = (tick_r != '0) && (tilt != prev_tilt_r);
    bump      = change && (change_r != '1);
    stat.count = change_r + CNT_W'(bump);
    stat.last  = ({1'b0, tick_r} + (CNT_W+1)'(1)) >= {1'b0, win_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tilt_r <= 1'b0;
      tick_r      <= '0;
      change_r    <= '0;
    end else if (accept) begin
      prev_tilt_r <= tilt;
      if (stat.last) begin
        tick_r   <= '0;
        change_r <= '0;
      end else begin
        tick_r   <= tick_r + CNT_W'(1);
        change_r <= stat.count;
      end
    end
  end

endmodule

`default_nettype wire

@@ test/meter_checker.sv @@
// ----------------------------------------------------------------------------
// meter_checker
// Watches the tilt meter's sample, result and register channels, predicts the
// result of every window end and compares each result item field by field.
// ----------------------------------------------------------------------------
module meter_checker
  import tam_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending_results,
  output int                     mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CNT_W-1:0]  count;
    level_t            level;
    grade_t            grade;
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } meter_result_t;

  // out_tdata layout, msb first
  typedef struct packed {
    logic [OUT_TDATA_W-CNT_W-LVL_W-GRADE_W-3*DUTY_W-1:0] pad;
    logic [DUTY_W-1:0]  blue;
    logic [DUTY_W-1:0]  green;
    logic [DUTY_W-1:0]  red;
    logic [GRADE_W-1:0] grade;
    logic [LVL_W-1:0]   level;
    logic [CNT_W-1:0]   count;
  } result_word_t;

  logic [CNT_W-1:0]   window_len;
  logic [CNT_W-1:0]   low_thr;
  logic [CNT_W-1:0]   medium_thr;
  logic [CNT_W-1:0]   high_thr;
  logic [LIMIT_W-1:0] few_limit;
  logic [LIMIT_W-1:0] many_limit;

  logic               last_tilt;
  logic [CNT_W-1:0]   change_cnt;
  logic [CNT_W-1:0]   tick_cnt;
  level_t             level_ring [HISTORY_DEPTH];
  int                 ring_slot;
  int                 level_tally [NUM_LVL];

  meter_result_t      expected_results [$];

  function automatic bit meter_tick(input logic tilt, output meter_result_t res);
    logic [CNT_W-1:0] span;
    level_t           lvl;
    grade_t           g;
    span = (window_len == '0) ? CNT_W'(1) : window_len;
    // first sample of a window only sets the reference level
    if (tick_cnt == '0) begin
      last_tilt = tilt;
    end else if (tilt != last_tilt) begin
      last_tilt = tilt;
      if (change_cnt != '1) change_cnt++;
    end
    tick_cnt++;
    if (tick_cnt < span) return 1'b0;

    res.count  = change_cnt;
    change_cnt = '0;
    tick_cnt   = '0;

    if (res.count >= high_thr) lvl = LVL_HIGH;
    else if (res.count >= medium_thr) lvl = LVL_MEDIUM;
    else if (res.count >= low_thr) lvl = LVL_LOW;
    else lvl = LVL_NONE;

    if (level_tally[level_ring[ring_slot]] > 0) level_tally[level_ring[ring_slot]]--;
    level_tally[lvl]++;
    level_ring[ring_slot] = lvl;
    ring_slot = (ring_slot + 1) % HISTORY_DEPTH;

    // later rules win
    g = GRADE_F;
    if (level_tally[LVL_LOW] >= few_limit) g = GRADE_E;
    if (level_tally[LVL_LOW] >= many_limit) g = GRADE_D;
    if (level_tally[LVL_MEDIUM] >= few_limit) g = GRADE_C;
    if (level_tally[LVL_MEDIUM] >= many_limit) g = GRADE_B;
    if (level_tally[LVL_HIGH] >= many_limit) g = GRADE_A;

    res.level = lvl;
    res.grade = g;
    case (g)
      GRADE_E: {res.red, res.green, res.blue} = {7'd100, 7'd10, 7'd0};
      GRADE_D: {res.red, res.green, res.blue} = {7'd100, 7'd30, 7'd0};
      GRADE_C: {res.red, res.green, res.blue} = {7'd0, 7'd100, 7'd0};
      GRADE_B: {res.red, res.green, res.blue} = {7'd0, 7'd100, 7'd80};
      GRADE_A: {res.red, res.green, res.blue} = {7'd0, 7'd0, 7'd100};
      default: {res.red, res.green, res.blue} = {7'd100, 7'd0, 7'd0};
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    meter_result_t res;
    result_word_t  word;
    if (!rst_n) begin
      window_len = RST_SAMPLES_PER_WINDOW;
      low_thr    = RST_LOW_THRESHOLD;
      medium_thr = RST_MEDIUM_THRESHOLD;
      high_thr   = RST_HIGH_THRESHOLD;
      few_limit  = RST_FEW_LIMIT;
      many_limit = RST_MANY_LIMIT;
      last_tilt  = 1'b0;
      change_cnt = '0;
      tick_cnt   = '0;
      ring_slot  = 0;
      foreach (level_ring[i]) level_ring[i] = LVL_NONE;
      foreach (level_tally[i]) level_tally[i] = 0;
      level_tally[LVL_NONE] = HISTORY_DEPTH;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        word = out_tdata;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: count %0d level %0d grade %0d",
                 word.count, word.level, word.grade);
          mismatch_count++;
        end else begin
          res = expected_results.pop_front();
          check_field("activation_count", res.count, word.count);
          check_field("activity_level", res.level, word.level);
          check_field("intensity_grade", res.grade, word.grade);
          check_field("red_duty", res.red, word.red);
          check_field("green_duty", res.green, word.green);
          check_field("blue_duty", res.blue, word.blue);
          check_field("out_tdata padding", 0, word.pad);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLES_PER_WINDOW: window_len = cfg_data;
          REG_LOW_THRESHOLD:      low_thr    = cfg_data;
          REG_MEDIUM_THRESHOLD:   medium_thr = cfg_data;
          REG_HIGH_THRESHOLD:     high_thr   = cfg_data;
          REG_FEW_LIMIT:          few_limit  = cfg_data[LIMIT_W-1:0];
          REG_MANY_LIMIT:         many_limit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (meter_tick(in_tdata[0], res)) expected_results.push_back(res);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives tilt samples and register writes into the activity meter: short
// windows at the reset thresholds, short directed windows, random windows of
// small length under changing settings and idle patterns, then one window of
// length one. The checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench import tam_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES       = 4;
  localparam int RANDOM_SEGMENTS     = 10;
  localparam int SAMPLES_PER_SEGMENT = 42;
  localparam int TIME_LIMIT_NS       = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_ready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pending_results;
  int mismatch_count;

  tilt_activity_intensity_meter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  meter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // returns at the rising edge where the item was taken
  task automatic send_sample(input logic tilt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, tilt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_sample(bits[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [CNT_W-1:0] win, input logic [CNT_W-1:0] low,
                              input logic [CNT_W-1:0] med, input logic [CNT_W-1:0] high,
                              input logic [LIMIT_W-1:0] few, input logic [LIMIT_W-1:0] many,
                              input bit poke_unused);
    wait_drained();
    put_reg(REG_SAMPLES_PER_WINDOW, win);
    put_reg(REG_LOW_THRESHOLD, low);
    put_reg(REG_MEDIUM_THRESHOLD, med);
    put_reg(REG_HIGH_THRESHOLD, high);
    put_reg(REG_FEW_LIMIT, CFG_DATA_W'(few));
    put_reg(REG_MANY_LIMIT, CFG_DATA_W'(many));
    if (poke_unused) put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_segment();
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] low;
    logic [CNT_W-1:0] med;
    logic [CNT_W-1:0] high;
    int               toggle_pct;
    logic             tilt;
    case ($urandom_range(0, 7))
      0:       win = '0;
      1:       win = CNT_W'($urandom_range(9, 40));
      default: win = CNT_W'($urandom_range(1, 8));
    endcase
    // mostly ordered small thresholds, sometimes any value
    low  = CNT_W'($urandom_range(0, 3));
    med  = low + CNT_W'($urandom_range(0, 3));
    high = med + CNT_W'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) low  = CNT_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0) med  = CNT_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0) high = CNT_W'($urandom_range(0, 65535));
    write_config(win, low, med, high, LIMIT_W'($urandom_range(0, 10)),
                 LIMIT_W'($urandom_range(0, 10)), 1'b0);
    toggle_pct = $urandom_range(0, 100);
    tilt       = 1'($urandom_range(0, 1));
    repeat (SAMPLES_PER_SEGMENT) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      if ($urandom_range(99) < toggle_pct) tilt = ~tilt;
      send_sample(tilt);
    end
  endtask

  initial begin
    logic tilt;
    send_idle_pct = 26;
    recv_idle_pct = 61;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short windows at the reset thresholds and limits
    put_reg(REG_SAMPLES_PER_WINDOW, 16'd20);
    cfg_valid <= 1'b0;
    tilt = 1'b0;
    repeat (60) begin
      if ($urandom_range(99) < 85) tilt = ~tilt;
      send_sample(tilt);
    end

    // zero window length acts as one, nothing is ever counted
    write_config('0, 16'd10, 16'd100, 16'd200, 4'd3, 4'd6, 1'b1);
    send_pattern(32'b0110, 4);
    // window start is not a change, even against the previous window's level
    write_config(16'd3, 16'd1, 16'd2, 16'd3, 4'd0, 4'd10, 1'b0);
    send_pattern(32'b101_010_111, 9);
    // thresholds out of order favour the higher level
    write_config(16'd2, 16'd2, 16'd1, 16'd1, 4'd10, 4'd0, 1'b0);
    send_pattern(32'b01_11, 4);
    write_config(16'd2, 16'd0, 16'hFFFF, 16'hFFFF, 4'd10, 4'd10, 1'b0);
    send_pattern(32'b00_10, 4);

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      if (seg == RANDOM_SEGMENTS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 26;
      end else if (seg == 2 * RANDOM_SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_random_segment();
    end

    // close any open window
    write_config(16'd1, 16'd100, 16'd65534, 16'hFFFF, 4'd1, 4'd1, 1'b0);
    send_sample(1'b0);

    wait_drained();
    if (mismatch_count == 0 && pending_results == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
